// ----- sv/shbt_pkg.sv -----
// Package for the spatial hash bucket table: constants, codes and shared types.
// No dependencies.
package shbt_pkg;

    localparam int MAX_BUCKETS_DEF  = 512;
    localparam int BUCKET_DEPTH_DEF = 16;
    localparam int MAX_POINTS_DEF   = 4096;
    localparam int MAX_RESULTS      = 16;

    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;
    localparam logic [9:0]  TABLE_SIZE_RESET = 10'd299;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EXH  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic mul;       // register the three products
        logic div_init;  // start remainder
        logic div_step;  // one restoring step
        logic fill_rd;   // read bucket fill
        logic clr_step;  // clear one fill entry
        logic clr_init;  // start clear sweep
        logic ins_wr;    // write id and fill
        logic cnt_inc;   // advance point count
        logic id_rd;     // read id entry (slot counter)
        logic slot_inc;  // advance slot
        logic slot_clr;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic clr_done;
        logic fill_zero;
        logic fill_full;
        logic exhausted;
        logic slot_last;
    } t_stat;

endpackage

// ----- sv/shbt_datapath.sv -----
// Datapath: hash products, iterative remainder, fill table, id memory.
// Depends on shbt_pkg.
module shbt_datapath #(
    parameter int MAX_BUCKETS  = shbt_pkg::MAX_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = shbt_pkg::BUCKET_DEPTH_DEF,
    parameter int MAX_POINTS   = shbt_pkg::MAX_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  shbt_pkg::t_cmd i_cmd,
    output shbt_pkg::t_stat o_stat,
    input  logic [9:0]     i_table_size,
    input  logic [31:0]    i_pos_x,
    input  logic [31:0]    i_pos_y,
    input  logic [31:0]    i_pos_z,
    output logic [8:0]     o_bucket,
    output logic [11:0]    o_id_new,
    output logic [11:0]    o_id_rd
);
    import shbt_pkg::*;

    localparam int BW  = $clog2(MAX_BUCKETS);
    localparam int DW  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW  = $clog2(BUCKET_DEPTH + 1);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SW  = BW + 1;
    localparam int DEP = MAX_BUCKETS * BUCKET_DEPTH;
    localparam int AW  = $clog2(DEP);

    logic [31:0] r_cx, r_cy, r_cz, r_hx, r_hy, r_hz;
    logic [31:0] r_q;
    logic [SW-1:0] r_rem, r_div;
    logic [5:0] r_step;
    logic [BW-1:0] r_clr;
    logic r_clr_done;
    logic [FW-1:0] fill_mem [MAX_BUCKETS];
    logic [11:0] id_mem [DEP];
    logic [FW-1:0] r_fill;
    logic [CW-1:0] r_cnt;
    logic [DW:0] r_slot;
    logic [11:0] r_id_rd;
    logic [SW-1:0] eff, trial_sh;
    logic [SW:0] trial;
    logic [BW-1:0] bkt;
    logic [AW-1:0] wr_addr, rd_addr;

    always_comb begin
        if (i_table_size == 10'd0) eff = SW'(1);
        else if (32'(i_table_size) > 32'(MAX_BUCKETS)) eff = SW'(MAX_BUCKETS);
        else eff = SW'(i_table_size);
    end

    assign trial    = {r_rem, r_q[31]} ;
    assign trial_sh = trial[SW-1:0];
    assign bkt      = r_rem[BW-1:0];
    assign wr_addr  = AW'(32'(bkt) * BUCKET_DEPTH + 32'(r_fill));
    assign rd_addr  = AW'(32'(bkt) * BUCKET_DEPTH + 32'(r_slot[DW-1:0]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= {{16{i_pos_x[31]}}, i_pos_x[31:16]};
            r_cy <= {{16{i_pos_y[31]}}, i_pos_y[31:16]};
            r_cz <= {{16{i_pos_z[31]}}, i_pos_z[31:16]};
            r_div <= eff;
        end
        if (i_cmd.mul) begin
            r_hx <= r_cx * PRIME_X;
            r_hy <= r_cy * PRIME_Y;
            r_hz <= r_cz * PRIME_Z;
        end
        if (i_cmd.div_init) begin
            r_q    <= r_hx ^ r_hy ^ r_hz;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            // restoring step: remainder stays below divisor so one more bit fits
            r_q    <= {r_q[30:0], 1'b0};
            r_step <= r_step + 6'd1;
            if (trial >= {1'b0, r_div}) r_rem <= SW'(trial - {1'b0, r_div});
            else r_rem <= trial_sh;
        end
        if (i_cmd.fill_rd) r_fill <= fill_mem[bkt];
        if (i_cmd.clr_step) fill_mem[r_clr] <= '0;
        else if (i_cmd.ins_wr) fill_mem[bkt] <= r_fill + FW'(1);
        if (i_cmd.ins_wr)
            id_mem[wr_addr] <= r_cnt[11:0];
        if (i_cmd.id_rd) r_id_rd <= id_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_clr_done <= 1'b0;
            r_cnt <= '0;
            r_slot <= '0;
        end else begin
            if (i_cmd.clr_init) begin
                r_clr <= '0;
                r_clr_done <= 1'b0;
                r_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + BW'(1);
                if (32'(r_clr) == MAX_BUCKETS - 1) r_clr_done <= 1'b1;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.slot_clr) r_slot <= '0;
            else if (i_cmd.slot_inc) r_slot <= r_slot + (DW+1)'(1);
        end
    end

    assign o_stat.div_done  = (r_step == 6'd32);
    assign o_stat.clr_done  = r_clr_done;
    assign o_stat.fill_zero = (r_fill == '0);
    assign o_stat.fill_full = (32'(r_fill) >= BUCKET_DEPTH);
    assign o_stat.exhausted = (32'(r_cnt) >= MAX_POINTS);
    assign o_stat.slot_last = (32'(r_slot) + 1 >= 32'(r_fill)) ||
                              (32'(r_slot) + 1 >= MAX_RESULTS);
    assign o_bucket = 9'(bkt);
    assign o_id_new = r_cnt[11:0];
    assign o_id_rd  = r_id_rd;

endmodule

// ----- sv/shbt_ctrl.sv -----
// Controller state machine and output register.
// Depends on shbt_pkg.
module shbt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_op,
    output shbt_pkg::t_cmd  o_cmd,
    input  shbt_pkg::t_stat i_stat,
    input  logic [8:0]      i_bucket,
    input  logic [11:0]     i_id_new,
    input  logic [11:0]     i_id_rd,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_kind,
    output logic [8:0]      o_bucket,
    output logic [11:0]     o_vertex_id,
    output logic            o_found,
    output logic            o_last,
    output logic [1:0]      o_status
);
    import shbt_pkg::*;

    localparam logic [3:0] S_RST   = 4'd0;  // clear sweep after reset
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DINIT = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_QRD   = 4'd7;
    localparam logic [3:0] S_QOUT  = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op;
    logic r_ovalid;
    logic [1:0] r_kind, r_status;
    logic [8:0] r_bucket;
    logic [11:0] r_vid;
    logic r_found, r_last;
    logic emit;
    logic [1:0] e_kind, e_status;
    logic [11:0] e_vid;
    logic e_found, e_last, e_bkt0;
    logic out_free;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        emit = 1'b0;
        e_kind = KIND_CLEAR; e_status = ST_OK; e_vid = '0;
        e_found = 1'b0; e_last = 1'b1; e_bkt0 = 1'b0;
        case (r_state)
            S_RST: begin
                o_cmd.clr_step = !i_stat.clr_done;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_op == OP_CLEAR) begin
                        o_cmd.clr_init = 1'b1;
                        n_state = S_CLR;
                    end else if (i_op == OP_UNUSED) n_state = S_IDLE;
                    else n_state = S_MUL;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = !i_stat.clr_done;
                if (i_stat.clr_done && out_free) begin
                    emit = 1'b1; e_bkt0 = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_FILL;
                else o_cmd.div_step = 1'b1;
            end
            S_FILL: begin
                o_cmd.fill_rd = 1'b1;
                o_cmd.slot_clr = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (r_op == OP_INSERT) begin
                    if (out_free) begin
                        emit = 1'b1; e_kind = KIND_INSERT;
                        n_state = S_IDLE;
                        if (i_stat.exhausted) e_status = ST_EXH;
                        else begin
                            e_vid = i_id_new;
                            o_cmd.cnt_inc = 1'b1;
                            if (i_stat.fill_full) e_status = ST_FULL;
                            else begin
                                e_found = 1'b1;
                                o_cmd.ins_wr = 1'b1;
                            end
                        end
                    end
                end else if (i_stat.fill_zero) begin
                    if (out_free) begin
                        emit = 1'b1; e_kind = KIND_QUERY;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.id_rd = 1'b1;
                    n_state = S_QOUT;
                end
            end
            S_QRD: begin
                o_cmd.id_rd = 1'b1;
                n_state = S_QOUT;
            end
            S_QOUT: begin
                if (out_free) begin
                    emit = 1'b1; e_kind = KIND_QUERY;
                    e_vid = i_id_rd; e_found = 1'b1;
                    e_last = i_stat.slot_last;
                    if (i_stat.slot_last) n_state = S_IDLE;
                    else begin
                        o_cmd.slot_inc = 1'b1;
                        n_state = S_QRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.load) r_op <= i_op;
        if (emit) begin
            r_kind   <= e_kind;
            r_bucket <= e_bkt0 ? 9'd0 : i_bucket;
            r_vid    <= e_vid;
            r_found  <= e_found;
            r_last   <= e_last;
            r_status <= e_status;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_kind      = r_kind;
    assign o_bucket    = r_bucket;
    assign o_vertex_id = r_vid;
    assign o_found     = r_found;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule

// ----- sv/spatial_hash_bucket_table.sv -----
// Spatial hash bucket table, top level: config register, controller, datapath.
// Depends on shbt_pkg, shbt_ctrl, shbt_datapath.
//
// Hashes 3D Q15.16 points to buckets (floor, prime multiply, XOR, modulo the
// table size, held to 1..MAX_BUCKETS) and stores point indices per bucket.
// Items are handled one at a time. An insert, or a query of an empty bucket,
// goes through one multiply stage, one remainder start, the 32-step restoring
// remainder unit, one fill table read and one decision step, then shows its
// result. A query with entries shows its first entry after the same steps and
// an id memory read, then each further entry after another id memory read and
// the output register. Clear sweeps the fill table, one bucket per cycle, and
// resets the point count. After reset the same sweep runs with ready low.
// A stalled output holds the block where it is. The user must write the table
// size register only while the block is idle; the block itself does not
// enforce it.
module spatial_hash_bucket_table #(
    parameter int MAX_BUCKETS  = shbt_pkg::MAX_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = shbt_pkg::BUCKET_DEPTH_DEF,
    parameter int MAX_POINTS   = shbt_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [8:0]  o_bucket,
    output logic [11:0] o_vertex_id,
    output logic        o_found,
    output logic        o_last,
    output logic [1:0]  o_status
);
    import shbt_pkg::*;

    logic [9:0] r_table_size;
    t_cmd  cmd;
    t_stat stat;
    logic [8:0]  bucket;
    logic [11:0] id_new, id_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_table_size <= TABLE_SIZE_RESET;
        else if (i_cfg_we) r_table_size <= i_cfg_data;
    end

    shbt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op,
        .o_cmd(cmd), .i_stat(stat), .i_bucket(bucket),
        .i_id_new(id_new), .i_id_rd(id_rd),
        .o_valid, .i_ready, .o_kind, .o_bucket, .o_vertex_id,
        .o_found, .o_last, .o_status
    );

    shbt_datapath #(
        .MAX_BUCKETS(MAX_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH), .MAX_POINTS(MAX_POINTS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_table_size(r_table_size),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .o_bucket(bucket), .o_id_new(id_new), .o_id_rd(id_rd)
    );

endmodule
